FILE: rtl/ile_pkg.sv
package ile_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned WordW    = 32;
  localparam int unsigned StW      = 2;
  localparam int unsigned CntOutW  = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CmdW-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic wr_shift_up;
    logic wr_shift_down;
    logic wr_word_idx;
    logic wr_word_end;
    logic ptr_from_idx;
    logic ptr_from_last;
    logic ptr_inc;
    logic ptr_dec;
    logic cnt_inc;
    logic cnt_dec;
    logic cap_rd;
    logic set_idx_err;
    logic set_full;
    logic push;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic idx_ok;
    logic full;
    logic ptr_at_idx;
    logic ptr_at_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/ile_datapath.sv
module ile_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ile_pkg::dp_cmd_t         cmd_i,
  output ile_pkg::dp_stat_t        stat_o,
  input  logic [ile_pkg::InDataW-1:0]  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ile_pkg::OutDataW-1:0] out_data_o
);
  import ile_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + CW + IdxW + 1;
  localparam logic [XW-1:0] CapX = XW'(CAPACITY);

  logic [WordW-1:0] mem_q [CAPACITY];
  logic [WordW-1:0] rdata_q;

  cmd_e             cmd_q;
  logic [IdxW-1:0]  idx_q;
  logic [WordW-1:0] word_q;
  logic [CW-1:0]    count_q;
  logic [AW-1:0]    ptr_q;
  logic [WordW-1:0] res_data_q;
  status_e          res_st_q;

  logic             out_valid_q;
  logic [WordW-1:0] out_word_q;
  status_e          out_st_q;
  logic [CntOutW-1:0] out_cnt_q;

  logic [XW-1:0] idx_x, cnt_x, ptr_x, ptr_nx;
  logic          we;
  logic [AW-1:0] waddr;
  logic [WordW-1:0] wdata;
  logic [CW+CntOutW-1:0] cnt_out_x;

  assign idx_x  = {{(XW-IdxW){1'b0}}, idx_q};
  assign cnt_x  = {{(XW-CW){1'b0}}, count_q};
  assign ptr_x  = {{(XW-AW){1'b0}}, ptr_q};
  assign ptr_nx = ptr_x + XW'(1);
  assign cnt_out_x = {{CntOutW{1'b0}}, count_q};

  assign stat_o.cmd         = cmd_q;
  assign stat_o.idx_ok      = idx_x < cnt_x;
  assign stat_o.full        = cnt_x >= CapX;
  assign stat_o.ptr_at_idx  = ptr_x == idx_x;
  assign stat_o.ptr_at_last = ptr_nx == cnt_x;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = word_q;
    if (cmd_i.wr_shift_up) begin
      we    = 1'b1;
      waddr = ptr_q + AW'(1);
      wdata = rdata_q;
    end else if (cmd_i.wr_shift_down) begin
      we    = 1'b1;
      waddr = ptr_q - AW'(1);
      wdata = rdata_q;
    end else if (cmd_i.wr_word_idx) begin
      we    = 1'b1;
      waddr = idx_x[AW-1:0];
    end else if (cmd_i.wr_word_end) begin
      we    = 1'b1;
      waddr = cnt_x[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[ptr_q];
    end
  end

  // transaction payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= cmd_e'(in_data_i[CmdW-1:0]);
      idx_q  <= in_data_i[CmdW +: IdxW];
      word_q <= in_data_i[CmdW+IdxW +: WordW];
    end
    if (cmd_i.ptr_from_idx) begin
      ptr_q <= idx_x[AW-1:0];
    end else if (cmd_i.ptr_from_last) begin
      ptr_q <= AW'(cnt_x - XW'(1));
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + AW'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_q - AW'(1);
    end
    if (cmd_i.load) begin
      res_data_q <= '0;
    end else if (cmd_i.cap_rd) begin
      res_data_q <= rdata_q;
    end
    if (cmd_i.load) begin
      res_st_q <= ST_OK;
    end else if (cmd_i.set_idx_err) begin
      res_st_q <= ST_INDEX;
    end else if (cmd_i.set_full) begin
      res_st_q <= ST_FULL;
    end
    if (cmd_i.push) begin
      out_word_q <= res_data_q;
      out_st_q   <= res_st_q;
      out_cnt_q  <= cnt_out_x[CntOutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OutDataW-WordW-StW-CntOutW){1'b0}}, out_cnt_q, out_st_q, out_word_q};

endmodule

FILE: rtl/ile_ctrl.sv
module ile_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ile_pkg::dp_stat_t stat_i,
  output ile_pkg::dp_cmd_t  cmd_o
);
  import ile_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_GET_RD   = 9'b000000100,
    S_GET_CAP  = 9'b000001000,
    S_SHIFT_RD = 9'b000010000,
    S_SHIFT_WR = 9'b000100000,
    S_PLACE    = 9'b001000000,
    S_REM_FIN  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (stat_i.cmd) inside
          CMD_GET, CMD_REMOVE: begin
            if (stat_i.idx_ok) begin
              cmd_o.ptr_from_idx = 1'b1;
              state_d            = S_GET_RD;
            end else begin
              cmd_o.set_idx_err = 1'b1;
            end
          end
          CMD_SET: begin
            if (stat_i.idx_ok) begin
              cmd_o.wr_word_idx = 1'b1;
            end else begin
              cmd_o.set_idx_err = 1'b1;
            end
          end
          CMD_APPEND: begin
            if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.wr_word_end = 1'b1;
              cmd_o.cnt_inc     = 1'b1;
            end
          end
          CMD_INSERT: begin
            if (!stat_i.idx_ok) begin
              cmd_o.set_idx_err = 1'b1;
            end else if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.ptr_from_last = 1'b1;
              state_d             = S_SHIFT_RD;
            end
          end
          default: ;
        endcase
      end
      S_GET_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_GET_CAP;
      end
      S_GET_CAP: begin
        cmd_o.cap_rd = 1'b1;
        if (stat_i.cmd != CMD_REMOVE) begin
          state_d = S_DONE;
        end else if (stat_i.ptr_at_last) begin
          state_d = S_REM_FIN;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        if (stat_i.cmd == CMD_INSERT) begin
          // move one element up, walking from the top down to the index
          cmd_o.wr_shift_up = 1'b1;
          if (stat_i.ptr_at_idx) begin
            state_d = S_PLACE;
          end else begin
            cmd_o.ptr_dec = 1'b1;
            state_d       = S_SHIFT_RD;
          end
        end else begin
          cmd_o.wr_shift_down = 1'b1;
          if (stat_i.ptr_at_last) begin
            state_d = S_REM_FIN;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = S_SHIFT_RD;
          end
        end
      end
      S_PLACE: begin
        cmd_o.wr_word_idx = 1'b1;
        cmd_o.cnt_inc     = 1'b1;
        state_d           = S_DONE;
      end
      S_REM_FIN: begin
        cmd_o.cnt_dec = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/indexed_list_engine_core.sv
// Ordered list of up to CAPACITY signed 32-bit words in a single-port-write
// memory with a registered read. Commands arrive on the slave stream and each
// returns exactly one result transaction on the master stream, held in an
// output register. One command is processed at a time. Get reads and captures
// the indexed element; set, append, unused codes and errors are decided in
// the decode state. Insert moves the elements from the last to the index up
// by one; remove moves the later ones down. The shift walk moves one element
// per read/write state pair through the one memory port. A result waits in
// the controller while an earlier result is still held in the output
// register. A new command can be accepted in the cycle after the previous
// result has been placed in the output register.
module indexed_list_engine_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [2:0] cmd, [6:3] index, [38:7] data_in, [39] zero
  input  logic [ile_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] data_out, [33:32] status, [38:34] item_count, [39] zero
  output logic [ile_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import ile_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ile_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ile_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
